### hw/rtl/flow_table_linear_probe_core_assert.svh
// assertion macros for the flow table core checker
// no dependencies; included by the checker file
`ifndef FLOW_TABLE_LINEAR_PROBE_CORE_ASSERT_SVH
`define FLOW_TABLE_LINEAR_PROBE_CORE_ASSERT_SVH

// same-cycle implication
`define FLPC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("flow table check failed");

// next-cycle implication
`define FLPC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("flow table check failed");

`endif

### hw/rtl/flpc_pkg.sv
// shared types, constants and helpers of the flow table core
// no dependencies; used by flpc_hash, the core and the checker
`default_nettype none

package flpc_pkg;

  localparam int CAPACITY    = 4096;
  localparam int PROBE_DEPTH = 32;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int PI_W        = $clog2(PROBE_DEPTH + 1);
  localparam int TO_W        = 40;
  localparam int LIM_W       = 13;
  localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int TIME_W      = 64;
  localparam int K0_W        = 64;
  localparam int K1_W        = 40;
  localparam int OUT_SLOT_W  = 12;
  localparam int OUT_CNT_W   = 13;
  localparam int IN_SLOT_W   = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 40;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [TO_W-1:0]  TCP_TO_RST  = 40'd300000000;
  localparam logic [TO_W-1:0]  UDP_TO_RST  = 40'd60000000;
  localparam logic [TO_W-1:0]  ICMP_TO_RST = 40'd30000000;
  localparam logic [LIM_W-1:0] LIMIT_RST   = 13'd1024;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_FIND   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_EXPIRE = 3'd3,
    OP_FLUSH  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_CREATED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_KEPT      = 3'd6,
    ST_FLUSHED   = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TCP   = 2'd0,
    CFG_UDP   = 2'd1,
    CFG_ICMP  = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_SLOT,
    S_EXPIRE,
    S_CHECK,
    S_SCAN,
    S_TMPRD,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic valid;
    logic tomb;
  } slot_st_t;

  typedef struct packed {
    logic [K0_W-1:0]   k0;
    logic [K1_W-1:0]   k1;
    logic [TIME_W-1:0] created;
    logic [TIME_W-1:0] last;
    logic              http;
    logic [SLOT_W-1:0] pdist;
  } entry_t;

  typedef struct packed {
    logic [K0_W-1:0]   k0;
    logic [K1_W-1:0]   k1;
    logic [TIME_W-1:0] created;
    logic [TIME_W-1:0] last;
    logic              http;
  } flow_t;

  typedef struct packed {
    logic            start;
    logic [K0_W-1:0] k0;
    logic [K1_W-1:0] k1;
  } hash_req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    entry_t            ent;
  } result_t;

  function automatic logic is_http(input logic [7:0] pr, input logic [15:0] spt);
    logic port_hit;
    port_hit = (spt == 16'd80) || (spt == 16'd8080) || (spt == 16'd8000) ||
               (spt == 16'd8888) || (spt == 16'd3128);
    return (pr == PROTO_TCP) && port_hit;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/flpc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module flpc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/flpc_hash.sv
// home slot hash: murmur3 64-bit finalizer of k0 ^ fmix(k1)
// depends on flpc_pkg; one shared 32x32 multiplier, 18 steps
`default_nettype none

module flpc_hash (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire flpc_pkg::hash_req_t       req,
  output logic                           done,
  output logic [flpc_pkg::SLOT_W-1:0]    home
);
  import flpc_pkg::*;

  logic              busy_r, busy_nxt;
  logic              pass_r, pass_nxt;
  logic [3:0]        step_r, step_nxt;
  logic [63:0]       x_r, x_nxt;
  logic [63:0]       k0_r, k0_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic              done_r, done_nxt;
  logic [SLOT_W-1:0] home_r, home_nxt;
  logic [63:0]       y, mix0, t, fin, cst;
  logic [31:0]       mul_a, mul_b;

  always_comb begin
    y    = pass_r ? (x_r ^ k0_r) : x_r;
    mix0 = y ^ (y >> 33);
    t    = acc_r + {prod_r[31:0], 32'd0};
    fin  = t ^ (t >> 33);
    cst  = (step_r < 4'd4) ? MIX_C1 : MIX_C2;
    mul_a = ((step_r == 4'd2) || (step_r == 4'd6)) ? x_r[63:32] : x_r[31:0];
    mul_b = ((step_r == 4'd3) || (step_r == 4'd7)) ? cst[63:32] : cst[31:0];
    prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};

    busy_nxt = busy_r;
    pass_nxt = pass_r;
    step_nxt = step_r;
    x_nxt    = x_r;
    k0_nxt   = k0_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    home_nxt = home_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      pass_nxt = 1'b0;
      step_nxt = 4'd0;
      x_nxt    = {24'd0, req.k1};
      k0_nxt   = req.k0;
    end else if (busy_r) begin
      step_nxt = step_r + 4'd1;
      case (step_r)
        4'd0: x_nxt = mix0;
        4'd2, 4'd6: acc_nxt = prod_r;
        4'd3, 4'd7: acc_nxt = t;
        4'd4: x_nxt = fin;
        4'd8: begin
          x_nxt = fin;
          if (pass_r) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            home_nxt = fin[SLOT_W-1:0];
          end else begin
            pass_nxt = 1'b1;
            step_nxt = 4'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    pass_r <= pass_nxt;
    step_r <= step_nxt;
    x_r    <= x_nxt;
    k0_r   <= k0_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    home_r <= home_nxt;
  end

  assign done = done_r;
  assign home = home_r;

endmodule

`default_nettype wire

### hw/rtl/flow_table_linear_probe_core.sv
// flow table core: open addressing with linear probing and tombstones
// depends on flpc_pkg, flpc_ram, flpc_hash
//
//  channel | signals                          | accepted when
//  in      | in_valid / in_ready, op and key   | in_valid & in_ready
//  out     | out_valid / out_ready, entry      | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_wdata      | cfg_we (no wait)
//
// after reset a clearing pass zeroes the slot state ram
// find / lookup / remove: hash of the key, then a probe from the home slot
// expire / flush: act on the sweep slot given with the request
// a rebuild scans every slot, then re-hashes and re-probes each live flow
// one item at a time; a finished item waits in the output register while
// the next item is taken and only stalls the engine at its own end
`default_nettype none

module flow_table_linear_probe_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_operation,
  input  wire logic [31:0]                     in_user_ip,
  input  wire logic [31:0]                     in_server_ip,
  input  wire logic [15:0]                     in_user_port,
  input  wire logic [15:0]                     in_server_port,
  input  wire logic [7:0]                      in_proto,
  input  wire logic [63:0]                     in_now_time,
  input  wire logic [flpc_pkg::IN_SLOT_W-1:0]  in_sweep_slot,
  input  wire logic                            in_sweep_end,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           out_status,
  output logic [flpc_pkg::OUT_SLOT_W-1:0]      out_entry_slot,
  output logic [31:0]                          out_entry_user_ip,
  output logic [31:0]                          out_entry_server_ip,
  output logic [15:0]                          out_entry_user_port,
  output logic [15:0]                          out_entry_server_port,
  output logic [7:0]                           out_entry_proto,
  output logic [63:0]                          out_created_time,
  output logic [63:0]                          out_last_time,
  output logic                                 out_is_http,
  output logic [flpc_pkg::OUT_SLOT_W-1:0]      out_probe_distance,
  output logic [flpc_pkg::OUT_CNT_W-1:0]       out_active_count,
  input  wire logic                            cfg_we,
  input  wire logic [flpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [flpc_pkg::CFG_W-1:0]      cfg_wdata
);
  import flpc_pkg::*;

  // configuration registers
  logic [TO_W-1:0]  tcp_to_r, udp_to_r, icmp_to_r;
  logic [LIM_W-1:0] lim_r;

  // control state
  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  tomb_r, tomb_nxt;
  logic              reb_r, reb_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;

  // per-item working registers
  logic [2:0]        op_r, op_nxt;
  logic              send_r, send_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  flow_t             cur_r, cur_nxt;
  logic [SLOT_W-1:0] home_r, home_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [PI_W-1:0]   pi_r, pi_nxt;
  logic              tf_r, tf_nxt;
  logic [SLOT_W-1:0] ts_r, ts_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [TIME_W-1:0] idle_r, idle_nxt;
  logic [TO_W-1:0]   to_r, to_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;
  logic [CNT_W-1:0]  out_act_r, out_act_nxt;

  // memory ports
  logic              st_we, ent_we, tmp_we;
  logic [SLOT_W-1:0] st_waddr, ent_waddr, rd_addr, tmp_raddr;
  slot_st_t          st_wdata, st_rd;
  entry_t            ent_wdata, ent_rd;
  flow_t             tmp_wdata, tmp_rd;

  hash_req_t         hreq;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_home;

  // probe decode
  logic              tf, last_probe, key_eq, resolve, hit, ins_ok;
  logic [SLOT_W-1:0] ts, ins;
  entry_t            new_ent, upd_ent;

  flpc_ram #(.W($bits(slot_st_t)), .D(CAPACITY)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rd)
  );

  flpc_ram #(.W($bits(entry_t)), .D(CAPACITY)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (rd_addr),
    .rdata (ent_rd)
  );

  // holding area for live flows during a rebuild
  flpc_ram #(.W($bits(flow_t)), .D(CAPACITY)) u_tmp_ram (
    .clk   (clk),
    .we    (tmp_we),
    .waddr (n_r[SLOT_W-1:0]),
    .wdata (tmp_wdata),
    .raddr (tmp_raddr),
    .rdata (tmp_rd)
  );

  flpc_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .done  (hash_done),
    .home  (hash_home)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcp_to_r  <= TCP_TO_RST;
      udp_to_r  <= UDP_TO_RST;
      icmp_to_r <= ICMP_TO_RST;
      lim_r     <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TCP:   tcp_to_r  <= cfg_wdata[TO_W-1:0];
        CFG_UDP:   udp_to_r  <= cfg_wdata[TO_W-1:0];
        CFG_ICMP:  icmp_to_r <= cfg_wdata[TO_W-1:0];
        CFG_LIMIT: lim_r     <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // probe step decode on the slot whose data sits at the ram outputs
  always_comb begin
    tf         = tf_r | st_rd.tomb;
    ts         = tf_r ? ts_r : slot_r;
    last_probe = (pi_r == PI_W'(PROBE_DEPTH - 1));
    key_eq     = (ent_rd.k0 == cur_r.k0) && (ent_rd.k1 == cur_r.k1);
    resolve    = 1'b0;
    hit        = 1'b0;
    ins_ok     = 1'b0;
    ins        = slot_r;
    if (st_rd.tomb) begin
      if (last_probe) begin
        resolve = 1'b1;
        ins_ok  = 1'b1;
        ins     = ts;
      end
    end else if (!st_rd.valid) begin
      // empty slot ends the probe; reuse the first tombstone if any
      resolve = 1'b1;
      ins_ok  = 1'b1;
      ins     = ts;
    end else if (key_eq) begin
      resolve = 1'b1;
      hit     = 1'b1;
    end else if (last_probe) begin
      resolve = 1'b1;
      ins_ok  = tf_r;
      ins     = ts_r;
    end

    new_ent.k0      = cur_r.k0;
    new_ent.k1      = cur_r.k1;
    new_ent.created = cur_r.created;
    new_ent.last    = cur_r.last;
    new_ent.http    = cur_r.http;
    new_ent.pdist   = ins - home_r;

    upd_ent      = ent_rd;
    upd_ent.last = now_r;
  end

  // main sequencer
  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    tomb_nxt      = tomb_r;
    reb_nxt       = reb_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    send_nxt      = send_r;
    now_nxt       = now_r;
    cur_nxt       = cur_r;
    home_nxt      = home_r;
    slot_nxt      = slot_r;
    pi_nxt        = pi_r;
    tf_nxt        = tf_r;
    ts_nxt        = ts_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    idle_nxt      = idle_r;
    to_nxt        = to_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_act_nxt   = out_act_r;
    out_valid_nxt = out_valid_r && !out_ready;

    in_ready  = 1'b0;
    hreq      = '0;
    rd_addr   = slot_r;
    st_we     = 1'b0;
    st_waddr  = slot_r;
    st_wdata  = '0;
    ent_we    = 1'b0;
    ent_waddr = slot_r;
    ent_wdata = new_ent;
    tmp_we    = 1'b0;
    tmp_wdata.k0      = ent_rd.k0;
    tmp_wdata.k1      = ent_rd.k1;
    tmp_wdata.created = ent_rd.created;
    tmp_wdata.last    = ent_rd.last;
    tmp_wdata.http    = ent_rd.http;

    case (state_r)
      S_CLEAR: begin
        // zero the slot state ram, one slot a cycle
        st_we    = 1'b1;
        st_waddr = idx_r;
        idx_nxt  = idx_r + SLOT_W'(1);
        if (idx_r == SLOT_W'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = SLOT_W'(in_sweep_slot);
        if (in_valid) begin
          res_nxt        = '0;
          res_nxt.status = ST_NOT_FOUND;
          op_nxt         = in_operation;
          send_nxt       = in_sweep_end;
          now_nxt        = in_now_time;
          slot_nxt       = SLOT_W'(in_sweep_slot);
          reb_nxt        = 1'b0;
          cur_nxt.k0      = {in_user_ip, in_server_ip};
          cur_nxt.k1      = {in_proto, in_user_port, in_server_port};
          cur_nxt.created = in_now_time;
          cur_nxt.last    = in_now_time;
          cur_nxt.http    = is_http(in_proto, in_server_port);
          case (in_operation)
            OP_LOOKUP, OP_FIND, OP_REMOVE: begin
              hreq.start = 1'b1;
              hreq.k0    = {in_user_ip, in_server_ip};
              hreq.k1    = {in_proto, in_user_port, in_server_port};
              state_nxt  = S_HASH;
            end
            OP_EXPIRE, OP_FLUSH: state_nxt = S_SLOT;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_HASH: begin
        rd_addr = hash_home;
        if (hash_done) begin
          home_nxt  = hash_home;
          slot_nxt  = hash_home;
          pi_nxt    = '0;
          tf_nxt    = 1'b0;
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        // read of the next slot goes out while this one is decoded
        rd_addr = slot_r + SLOT_W'(1);
        if (!resolve) begin
          slot_nxt = slot_r + SLOT_W'(1);
          pi_nxt   = pi_r + PI_W'(1);
          tf_nxt   = tf;
          ts_nxt   = ts;
        end else if (reb_r) begin
          // re-insertion of a saved flow
          if (!hit && ins_ok) begin
            st_we          = 1'b1;
            st_waddr       = ins;
            st_wdata.valid = 1'b1;
            ent_we         = 1'b1;
            ent_waddr      = ins;
            live_nxt       = live_r + CNT_W'(1);
          end
          j_nxt = j_r + CNT_W'(1);
          if (j_r + CNT_W'(1) == n_r) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TMPRD;
          end
        end else begin
          state_nxt = S_DONE;
          case (op_r)
            OP_LOOKUP: begin
              if (hit) begin
                ent_we         = 1'b1;
                ent_wdata      = upd_ent;
                res_nxt.status = ST_HIT;
                res_nxt.slot   = slot_r;
                res_nxt.ent    = upd_ent;
              end else if (!ins_ok) begin
                res_nxt.status = ST_FULL;
              end else begin
                st_we          = 1'b1;
                st_waddr       = ins;
                st_wdata.valid = 1'b1;
                ent_we         = 1'b1;
                ent_waddr      = ins;
                live_nxt       = live_r + CNT_W'(1);
                // slot taken from a tombstone
                if (tf) begin
                  tomb_nxt = tomb_r - CNT_W'(1);
                end
                res_nxt.status = ST_CREATED;
                res_nxt.slot   = ins;
                res_nxt.ent    = new_ent;
              end
            end
            OP_FIND: begin
              if (hit) begin
                res_nxt.status = ST_HIT;
                res_nxt.slot   = slot_r;
                res_nxt.ent    = ent_rd;
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                res_nxt.status = ST_REMOVED;
                res_nxt.slot   = slot_r;
                res_nxt.ent    = ent_rd;
                st_we          = 1'b1;
                st_wdata.tomb  = 1'b1;
                live_nxt       = live_r - CNT_W'(1);
                tomb_nxt       = tomb_r + CNT_W'(1);
                state_nxt      = S_CHECK;
              end
            end
            default: ;
          endcase
        end
      end

      S_SLOT: begin
        state_nxt = send_r ? S_CHECK : S_DONE;
        case (op_r)
          OP_EXPIRE: begin
            if (st_rd.valid) begin
              res_nxt.slot = slot_r;
              res_nxt.ent  = ent_rd;
              // a clock that went backwards counts as no idle time
              idle_nxt     = (now_r > ent_rd.last) ? (now_r - ent_rd.last) : '0;
              if (ent_rd.k1[K1_W-1 -: 8] == PROTO_TCP) begin
                to_nxt = tcp_to_r;
              end else if (ent_rd.k1[K1_W-1 -: 8] == PROTO_ICMP) begin
                to_nxt = icmp_to_r;
              end else begin
                to_nxt = udp_to_r;
              end
              state_nxt = S_EXPIRE;
            end
          end
          OP_FLUSH: begin
            if (st_rd.valid) begin
              res_nxt.status = ST_FLUSHED;
              res_nxt.slot   = slot_r;
              res_nxt.ent    = ent_rd;
              st_we          = 1'b1;
              live_nxt       = live_r - CNT_W'(1);
            end else if (st_rd.tomb) begin
              st_we    = 1'b1;
              tomb_nxt = tomb_r - CNT_W'(1);
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_EXPIRE: begin
        state_nxt = send_r ? S_CHECK : S_DONE;
        if (idle_r > {{(TIME_W - TO_W){1'b0}}, to_r}) begin
          res_nxt.status = ST_EXPIRED;
          st_we          = 1'b1;
          st_wdata.tomb  = 1'b1;
          live_nxt       = live_r - CNT_W'(1);
          tomb_nxt       = tomb_r + CNT_W'(1);
        end else begin
          res_nxt.status = ST_KEPT;
        end
      end

      S_CHECK: begin
        if (CMP_W'(tomb_r) >= CMP_W'(lim_r)) begin
          rd_addr   = '0;
          idx_nxt   = '0;
          n_nxt     = '0;
          reb_nxt   = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        // copy live flows out in ascending slot order and clear the slot
        rd_addr  = idx_r + SLOT_W'(1);
        st_we    = 1'b1;
        st_waddr = idx_r;
        idx_nxt  = idx_r + SLOT_W'(1);
        if (st_rd.valid) begin
          tmp_we = 1'b1;
          n_nxt  = n_r + CNT_W'(1);
        end
        if (idx_r == SLOT_W'(CAPACITY - 1)) begin
          live_nxt = '0;
          tomb_nxt = '0;
          j_nxt    = '0;
          if (n_nxt == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TMPRD;
          end
        end
      end

      S_TMPRD: begin
        cur_nxt    = tmp_rd;
        hreq.start = 1'b1;
        hreq.k0    = tmp_rd.k0;
        hreq.k1    = tmp_rd.k1;
        state_nxt  = S_HASH;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_act_nxt   = live_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    tmp_raddr = j_nxt[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      live_r      <= '0;
      tomb_r      <= '0;
      reb_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      tomb_r      <= tomb_nxt;
      reb_r       <= reb_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    op_r      <= op_nxt;
    send_r    <= send_nxt;
    now_r     <= now_nxt;
    cur_r     <= cur_nxt;
    home_r    <= home_nxt;
    slot_r    <= slot_nxt;
    pi_r      <= pi_nxt;
    tf_r      <= tf_nxt;
    ts_r      <= ts_nxt;
    n_r       <= n_nxt;
    j_r       <= j_nxt;
    idle_r    <= idle_nxt;
    to_r      <= to_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    out_act_r <= out_act_nxt;
  end

  // result register fan-out
  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_entry_slot        = OUT_SLOT_W'(out_r.slot);
  assign out_entry_user_ip     = out_r.ent.k0[63:32];
  assign out_entry_server_ip   = out_r.ent.k0[31:0];
  assign out_entry_user_port   = out_r.ent.k1[31:16];
  assign out_entry_server_port = out_r.ent.k1[15:0];
  assign out_entry_proto       = out_r.ent.k1[K1_W-1 -: 8];
  assign out_created_time      = out_r.ent.created;
  assign out_last_time         = out_r.ent.last;
  assign out_is_http           = out_r.ent.http;
  assign out_probe_distance    = OUT_SLOT_W'(out_r.ent.pdist);
  assign out_active_count      = OUT_CNT_W'(out_act_r);

endmodule

`default_nettype wire

### hw/rtl/flpc_checker.sv
// port-level checks of the flow table core, bound to the top level
// depends on flpc_pkg and flow_table_linear_probe_core_assert.svh
`default_nettype none
`include "flow_table_linear_probe_core_assert.svh"

module flpc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [2:0]                     out_status,
  input wire logic [flpc_pkg::OUT_CNT_W-1:0] out_active_count
);
  import flpc_pkg::*;

  // a stalled result holds
  `FLPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `FLPC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_status) && $stable(out_active_count))
  // one item in the engine at a time
  `FLPC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  // a hit or a create leaves at least one live flow
  `FLPC_ASSERT_IMPL(a_live_flow, clk, rst_n, out_valid && (out_status == ST_HIT || out_status == ST_CREATED), out_active_count != '0)

endmodule

bind flow_table_linear_probe_core flpc_checker u_flpc_checker (.*);

`default_nettype wire
